/* hw/rtl/sliding_window_minimum_assert.svh */
// assertion macros for the sliding window minimum block
`ifndef SLIDING_WINDOW_MINIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MINIMUM_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define SWM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SWM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/swm_pkg.sv */
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WS_W     = 11;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_back;
        logic drop_front;
        logic pop_back;
        logic push;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic age_expired;
        logic back_ge;
        logic filled;
        logic out_free;
    } sts_t;

endpackage

/* hw/rtl/swm_ram.sv */
module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/swm_datapath.sv */
module swm_datapath #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [swm_pkg::WS_W-1:0]     window_size,
    input  logic [swm_pkg::SAMPLE_W-1:0] sample,
    input  logic                         new_sequence,
    input  swm_pkg::cmd_t                cmd,
    output swm_pkg::sts_t                sts,
    output logic                         out_valid,
    output logic [swm_pkg::SAMPLE_W-1:0] out_data,
    input  logic                         out_ready
);

    localparam int AW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW      = $clog2(WINDOW_MAX + 1);
    localparam int PW      = $clog2(2 * WINDOW_MAX);
    localparam int POS_MOD = 2 * WINDOW_MAX;
    localparam int WCW     = (CW > swm_pkg::WS_W) ? CW : swm_pkg::WS_W;
    localparam int SW      = swm_pkg::SAMPLE_W;
    localparam int RW      = PW + SW;

    logic [AW-1:0]        front_ptr_reg, front_ptr_next;
    logic [AW-1:0]        back_ptr_reg, back_ptr_next;
    logic [CW-1:0]        cand_count_reg, cand_count_next;
    logic [PW-1:0]        sample_position_reg, sample_position_next;
    logic [CW-1:0]        seq_count_reg, seq_count_next;
    logic                 window_filled_reg, window_filled_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [SW-1:0] smp_reg;
    logic [SW-1:0]        out_data_reg;

    logic [AW-1:0]        front_inc, back_inc, back_dec;
    logic [CW-1:0]        ws_eff, seq_inc;
    logic [WCW-1:0]       ws_ext;
    logic [PW:0]          age;
    logic [RW-1:0]        rd_data;
    logic signed [SW-1:0] rd_value;
    logic [PW-1:0]        rd_pos;
    logic [AW-1:0]        rd_addr;

    // ring index steps
    assign front_inc = (front_ptr_reg == AW'(WINDOW_MAX - 1)) ? '0 : front_ptr_reg + 1'b1;
    assign back_inc  = (back_ptr_reg == AW'(WINDOW_MAX - 1)) ? '0 : back_ptr_reg + 1'b1;
    assign back_dec  = (back_ptr_reg == '0) ? AW'(WINDOW_MAX - 1) : back_ptr_reg - 1'b1;

    // window clamped to 1..WINDOW_MAX
    assign ws_ext = WCW'(window_size);
    always_comb
    begin
        if (window_size == '0)
        begin
            ws_eff = CW'(1);
        end
        else if (ws_ext > WCW'(WINDOW_MAX))
        begin
            ws_eff = CW'(WINDOW_MAX);
        end
        else
        begin
            ws_eff = CW'(ws_ext);
        end
    end

    assign rd_addr  = cmd.rd_back ? back_dec : front_ptr_reg;
    assign rd_value = rd_data[SW-1:0];
    assign rd_pos   = rd_data[RW-1:SW];

    swm_ram #(
        .WIDTH (RW),
        .DEPTH (WINDOW_MAX)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (back_ptr_reg),
        .wr_data ({sample_position_reg, smp_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // age of the front candidate, positions wrap at twice the window limit
    always_comb
    begin
        if (sample_position_reg >= rd_pos)
        begin
            age = {1'b0, sample_position_reg} - {1'b0, rd_pos};
        end
        else
        begin
            age = {1'b0, sample_position_reg} + (PW + 1)'(POS_MOD) - {1'b0, rd_pos};
        end
    end

    assign seq_inc = (seq_count_reg == CW'(WINDOW_MAX)) ? seq_count_reg : seq_count_reg + 1'b1;

    assign sts.cnt_zero    = (cand_count_reg == '0);
    assign sts.age_expired = (age >= (PW + 1)'(ws_eff));
    assign sts.back_ge     = (rd_value >= smp_reg);
    assign sts.filled      = window_filled_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        front_ptr_next       = front_ptr_reg;
        back_ptr_next        = back_ptr_reg;
        cand_count_next      = cand_count_reg;
        sample_position_next = sample_position_reg;
        seq_count_next       = seq_count_reg;
        window_filled_next   = window_filled_reg;
        out_valid_next       = out_valid_reg && !out_ready;
        if (cmd.accept && new_sequence)
        begin
            front_ptr_next       = '0;
            back_ptr_next        = '0;
            cand_count_next      = '0;
            sample_position_next = '0;
            seq_count_next       = '0;
            window_filled_next   = 1'b0;
        end
        if (cmd.drop_front)
        begin
            front_ptr_next  = front_inc;
            cand_count_next = cand_count_reg - 1'b1;
        end
        if (cmd.pop_back)
        begin
            back_ptr_next   = back_dec;
            cand_count_next = cand_count_reg - 1'b1;
        end
        if (cmd.push)
        begin
            back_ptr_next = back_inc;
            if (cand_count_reg == CW'(WINDOW_MAX))
            begin
                front_ptr_next = front_inc;
            end
            else
            begin
                cand_count_next = cand_count_reg + 1'b1;
            end
            sample_position_next = (sample_position_reg == PW'(POS_MOD - 1)) ? '0
                                 : sample_position_reg + 1'b1;
            seq_count_next       = seq_inc;
            window_filled_next   = window_filled_reg || (seq_inc >= ws_eff);
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_ptr_reg       <= '0;
            back_ptr_reg        <= '0;
            cand_count_reg      <= '0;
            sample_position_reg <= '0;
            seq_count_reg       <= '0;
            window_filled_reg   <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            front_ptr_reg       <= front_ptr_next;
            back_ptr_reg        <= back_ptr_next;
            cand_count_reg      <= cand_count_next;
            sample_position_reg <= sample_position_next;
            seq_count_reg       <= seq_count_next;
            window_filled_reg   <= window_filled_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            smp_reg <= sample;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= rd_value;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* hw/rtl/swm_ctrl.sv */
module swm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  swm_pkg::sts_t sts,
    output swm_pkg::cmd_t cmd
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_FRONT_RD  = 8'b0000_0010,
        ST_FRONT_CHK = 8'b0000_0100,
        ST_BACK_RD   = 8'b0000_1000,
        ST_BACK_CHK  = 8'b0001_0000,
        ST_PUSH      = 8'b0010_0000,
        ST_HEAD_RD   = 8'b0100_0000,
        ST_DONE      = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_FRONT_RD;
                end
            end
            ST_FRONT_RD:
            begin
                // read address defaults to the front slot
                state_next = sts.cnt_zero ? ST_BACK_RD : ST_FRONT_CHK;
            end
            ST_FRONT_CHK:
            begin
                if (sts.age_expired)
                begin
                    cmd.drop_front = 1'b1;
                    state_next     = ST_FRONT_RD;
                end
                else
                begin
                    state_next = ST_BACK_RD;
                end
            end
            ST_BACK_RD:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    cmd.rd_back = 1'b1;
                    state_next  = ST_BACK_CHK;
                end
            end
            ST_BACK_CHK:
            begin
                if (sts.back_ge)
                begin
                    cmd.pop_back = 1'b1;
                    state_next   = ST_BACK_RD;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = ST_HEAD_RD;
            end
            ST_HEAD_RD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.filled)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/sliding_window_minimum.sv */
// sliding window minimum over a stream of signed 32-bit samples
// input stream: s_tdata carries the sample, s_tuser flags the first sample
//   of a new sequence, which clears the candidate deque and the counters
// output stream: m_tdata carries the minimum of the last window_size samples,
//   one transfer per sample once window_size samples of the sequence arrived;
//   earlier samples of a sequence give no output transfer
// config: cfg_we writes cfg_wdata into window_size (0 acts as 1, values above
//   WINDOW_MAX act as WINDOW_MAX); write it only while the block is idle
// timing: one sample at a time; each candidate dropped from the front or popped
//   from the back adds a read step and a check step, all set by the single read
//   port of the candidate ram; each candidate leaves the deque at most once
// result: m_tvalid rises after the front walk, back walk, push, head read and
//   done steps of the walk for that sample
// reset: clears deque, counters and output valid; window_size returns to 1;
//   the candidate ram is not cleared and needs no clearing pass
// stall: a result waits in the output register while the next sample is
//   taken in and worked on; that sample finishes once the register is free
module sliding_window_minimum #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // config register
    input  logic                         cfg_we,
    input  logic [swm_pkg::WS_W-1:0]     cfg_wdata,     // window_size
    // sample stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [swm_pkg::SAMPLE_W-1:0] s_tdata,       // [31:0] sample
    input  logic                         s_tuser,       // [0] new_sequence
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [swm_pkg::SAMPLE_W-1:0] m_tdata        // [31:0] window_min
);

    logic [swm_pkg::WS_W-1:0] window_size_reg;
    swm_pkg::cmd_t            cmd;
    swm_pkg::sts_t            sts;

    // window size register, reset to a window of one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swm_pkg::WS_W'(1);
        end
        else if (cfg_we)
        begin
            window_size_reg <= cfg_wdata;
        end
    end

    // sequencer: front expiry walk, back pop walk, push, head read
    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // deque pointers, counters, candidate ram and output register
    swm_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_size  (window_size_reg),
        .sample       (s_tdata),
        .new_sequence (s_tuser),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (m_tvalid),
        .out_data     (m_tdata),
        .out_ready    (m_tready)
    );

`include "sliding_window_minimum_assert.svh"

    // a sample transfer starts the walk, so the next cycle is busy
    `SWM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "ready after accept")
    // a result is loaded only from the final step of a walk, never from idle
    `SWM_ASSERT_IMPLIES(a_result_from_walk, clk, rst_n, $rose(m_tvalid), !$past(s_tready), "result from idle")
    // a result is never loaded in the cycle a sample is taken
    `SWM_ASSERT_NEXT(a_no_load_on_accept, clk, rst_n, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "early result")

endmodule
